[rtl/wavhp_pkg.sv]
// Shared types and constants of the WAV header parser.
package wavhp_pkg;

   // result status codes
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_BAD_HEADER  = 3'd1;
   localparam logic [2:0] STATUS_UNSUPPORTED = 3'd2;
   localparam logic [2:0] STATUS_TRUNCATED   = 3'd3;
   localparam logic [2:0] STATUS_ZERO_CHAN   = 3'd4;

   // chunk tags as little-endian words
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_MIN_LEN = 32'd16;
   localparam int          HEADER_LEN  = 12;
   localparam logic [15:0] PCM_TAG     = 16'd1;

   // packed so that status lands in the lowest bits
   typedef struct packed {
      logic [31:0] frame_count;
      logic [31:0] data_offset;
      logic [4:0]  sample_bits;
      logic [31:0] sample_hz;
      logic [1:0]  channels;
      logic [2:0]  status;
   } rsp_type;

   localparam int RSP_BITS   = $bits(rsp_type);
   localparam int TDATA_BITS = ((RSP_BITS + 7) / 8) * 8;

endpackage

[rtl/wav_header_parser.sv]
// Top level of the WAV (RIFF/WAVE PCM) header parser.
//
// Usage:
//  - req channel: one beat per file byte, in file order. tlast marks the
//    final byte of a file; the next beat then starts a new file.
//  - rsp channel: at most one beat per file. It carries status and the
//    format and data chunk figures once both chunks are seen, or an error
//    status (bad header, unsupported format, truncated) when the error is
//    found or the file ends first. Bytes after a result are dropped until
//    tlast.
//  - Throughput: one byte per cycle, sustained, while results are taken.
//  - Output path: the byte that completes a result is held in the input
//    register, then the result is written to the result buffer, which
//    drives rsp_tvalid.
//  - Stall: a two-entry result buffer holds results while rsp_tready is
//    low; req_tready drops only when that buffer is full and a byte waits.
//  - Reset: clear all control state; the parser waits for the RIFF header
//    of a new file and the result buffer is empty.
module wav_header_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [7:0] byte_value
   input  logic                             req_tlast,  // end_of_stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [2:0] status, [4:3] channels, [36:5] sample_hz, [41:37] sample_bits,
   // [73:42] data_offset, [105:74] frame_count, [111:106] zero
   output logic [wavhp_pkg::TDATA_BITS-1:0] rsp_tdata
);

   logic               res_valid;
   wavhp_pkg::rsp_type res_data;
   logic               buf_room;
   wavhp_pkg::rsp_type rsp_q;

   // parse one byte per cycle from the input register while the result buffer has room
   wavhp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .out_room  (buf_room),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // hold results until the receiver takes them
   wavhp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .room      (buf_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_q)
   );

   // pad the result up to whole bytes
   assign rsp_tdata = {{(wavhp_pkg::TDATA_BITS - wavhp_pkg::RSP_BITS){1'b0}}, rsp_q};

   // a result is only produced when the buffer has room for it
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> buf_room)
      else $error("result pushed into a full buffer");

   // a good result always carries a supported PCM format
   a_ok_format: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_q.status == wavhp_pkg::STATUS_OK) |->
      ((rsp_q.sample_bits == 5'd8 || rsp_q.sample_bits == 5'd16) &&
       (rsp_q.channels == 2'd1 || rsp_q.channels == 2'd2)))
      else $error("ok result with unsupported format fields");

   // error results carry no figures
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_q.status == wavhp_pkg::STATUS_BAD_HEADER ||
                      rsp_q.status == wavhp_pkg::STATUS_UNSUPPORTED ||
                      rsp_q.status == wavhp_pkg::STATUS_TRUNCATED)) |->
      (rsp_q.channels == 2'd0 && rsp_q.sample_hz == 32'd0 &&
       rsp_q.sample_bits == 5'd0 && rsp_q.data_offset == 32'd0 &&
       rsp_q.frame_count == 32'd0))
      else $error("error result with nonzero fields");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat offered after reset");

endmodule

[rtl/wavhp_parse.sv]
// Byte input register and header parsing step, one byte per cycle while the result buffer has room.
module wavhp_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         in_byte,
   input  logic               in_last,
   input  logic               out_room,
   output logic               res_valid,
   output wavhp_pkg::rsp_type res_data
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_CHUNK  = 3'd1;
   localparam logic [2:0] PH_FORMAT = 3'd2;
   localparam logic [2:0] PH_SKIP   = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   localparam logic [3:0] HDR_LAST_IDX = 4'(wavhp_pkg::HEADER_LEN - 1);

   // input register
   logic       v_ff, v_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   // parser state
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] skip_ff, skip_in;
   logic [31:0] pos_ff, pos_in;
   logic [15:0] ch_ff, ch_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] doff_ff, doff_in;
   logic [31:0] dlen_ff, dlen_in;
   logic        fmt_done_ff, fmt_done_in;
   logic        data_ff, data_in;
   logic        aux_ff, aux_in;

   logic        fire;
   logic [31:0] pos_nx;
   logic [31:0] tag_m, size_m, rate_m;
   logic [15:0] ch_m, bits_m;
   logic        emit_ok, emit_err;
   logic [2:0]  err_code;
   logic [1:0]  shift_amt;

   assign fire     = v_ff && out_room;
   assign in_ready = !v_ff || out_room;
   assign v_in     = (in_valid && in_ready) || (v_ff && !fire);
   assign pos_nx   = pos_ff + 32'd1;

   // merge the current byte into each field at its lane
   always_comb begin
      tag_m  = tag_ff;
      size_m = size_ff;
      rate_m = rate_ff;
      ch_m   = ch_ff;
      bits_m = bits_ff;
      tag_m[{idx_ff[1:0], 3'b000} +: 8]  = byte_ff;
      size_m[{idx_ff[1:0], 3'b000} +: 8] = byte_ff;
      rate_m[{idx_ff[1:0], 3'b000} +: 8] = byte_ff;
      ch_m[{idx_ff[0], 3'b000} +: 8]     = byte_ff;
      bits_m[{idx_ff[0], 3'b000} +: 8]   = byte_ff;
   end

   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      tag_in      = tag_ff;
      size_in     = size_ff;
      skip_in     = skip_ff;
      pos_in      = pos_ff;
      ch_in       = ch_ff;
      rate_in     = rate_ff;
      bits_in     = bits_ff;
      doff_in     = doff_ff;
      dlen_in     = dlen_ff;
      fmt_done_in = fmt_done_ff;
      data_in     = data_ff;
      aux_in      = aux_ff;
      emit_ok     = 1'b0;
      emit_err    = 1'b0;
      err_code    = wavhp_pkg::STATUS_OK;
      if (fire) begin
         pos_in = pos_nx;
         idx_in = idx_ff + 4'd1;
         unique case (phase_ff)
            PH_HEADER: begin
               if (idx_ff < 4'd4 || idx_ff > 4'd7) begin
                  tag_in = tag_m;
               end else begin
                  size_in = size_m;
               end
               if (idx_ff == 4'd3) begin
                  if (tag_m != wavhp_pkg::TAG_RIFF) aux_in = 1'b1;
               end else if (idx_ff == 4'd7) begin
                  if (size_m == 32'd0) aux_in = 1'b1;
               end else if (idx_ff == HDR_LAST_IDX) begin
                  idx_in = 4'd0;
                  aux_in = 1'b0;
                  if (aux_ff || tag_m != wavhp_pkg::TAG_WAVE) begin
                     emit_err = 1'b1;
                     err_code = wavhp_pkg::STATUS_BAD_HEADER;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_CHUNK;
                  end
               end
            end
            PH_CHUNK: begin
               if (idx_ff < 4'd4) begin
                  tag_in = tag_m;
               end else begin
                  size_in = size_m;
               end
               if (idx_ff == 4'd7) begin
                  idx_in = 4'd0;
                  if (tag_ff == wavhp_pkg::TAG_FMT && size_m >= wavhp_pkg::FMT_MIN_LEN &&
                      !fmt_done_ff) begin
                     phase_in = PH_FORMAT;
                  end else if (tag_ff == wavhp_pkg::TAG_DATA && !data_ff) begin
                     doff_in = pos_nx;
                     dlen_in = size_m;
                     data_in = 1'b1;
                     if (fmt_done_ff) begin
                        emit_ok  = 1'b1;
                        phase_in = PH_DONE;
                     end else if (size_m == 32'd0) begin
                        phase_in = PH_CHUNK;
                     end else begin
                        skip_in  = size_m;
                        phase_in = PH_SKIP;
                     end
                  end else if (size_m == 32'd0) begin
                     phase_in = PH_CHUNK;
                  end else begin
                     skip_in  = size_m;
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_FORMAT: begin
               if (idx_ff < 4'd2) tag_in = tag_m;
               else if (idx_ff < 4'd4) ch_in = ch_m;
               else if (idx_ff < 4'd8) rate_in = rate_m;
               else if (idx_ff > 4'd13) bits_in = bits_m;
               if (idx_ff == 4'd15) begin
                  idx_in = 4'd0;
                  // only the low half of the tag is loaded in this chunk
                  if (tag_ff[15:0] != wavhp_pkg::PCM_TAG || ch_ff > 16'd2 ||
                      (bits_m != 16'd8 && bits_m != 16'd16)) begin
                     emit_err = 1'b1;
                     err_code = wavhp_pkg::STATUS_UNSUPPORTED;
                     phase_in = PH_DONE;
                  end else if (size_ff == wavhp_pkg::FMT_MIN_LEN) begin
                     fmt_done_in = 1'b1;
                     if (data_ff) begin
                        emit_ok  = 1'b1;
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_CHUNK;
                     end
                  end else begin
                     aux_in   = 1'b1;
                     skip_in  = size_ff - wavhp_pkg::FMT_MIN_LEN;
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               idx_in  = idx_ff;
               skip_in = skip_ff - 32'd1;
               if (skip_ff == 32'd1) begin
                  phase_in = PH_CHUNK;
                  if (aux_ff) begin
                     aux_in      = 1'b0;
                     fmt_done_in = 1'b1;
                     if (data_ff) begin
                        emit_ok  = 1'b1;
                        phase_in = PH_DONE;
                     end
                  end
               end
            end
            default: begin
               idx_in = idx_ff;
            end
         endcase
         if (last_ff) begin
            if (!emit_ok && !emit_err && phase_in != PH_DONE) begin
               emit_err = 1'b1;
               err_code = (phase_in == PH_HEADER) ? wavhp_pkg::STATUS_BAD_HEADER
                                                  : wavhp_pkg::STATUS_TRUNCATED;
            end
            phase_in    = PH_HEADER;
            idx_in      = 4'd0;
            pos_in      = 32'd0;
            fmt_done_in = 1'b0;
            data_in     = 1'b0;
            aux_in      = 1'b0;
         end
      end
   end

   assign shift_amt = {1'b0, ch_in == 16'd2} + {1'b0, bits_in == 16'd16};

   always_comb begin
      res_valid = emit_ok || emit_err;
      res_data  = '0;
      if (emit_err) begin
         res_data.status = err_code;
      end else if (emit_ok) begin
         res_data.channels    = ch_in[1:0];
         res_data.sample_hz   = rate_in;
         res_data.sample_bits = bits_in[4:0];
         res_data.data_offset = doff_in;
         if (ch_in == 16'd0) begin
            res_data.status = wavhp_pkg::STATUS_ZERO_CHAN;
         end else begin
            res_data.status      = wavhp_pkg::STATUS_OK;
            res_data.frame_count = dlen_in >> shift_amt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff        <= 1'b0;
         phase_ff    <= PH_HEADER;
         idx_ff      <= 4'd0;
         pos_ff      <= 32'd0;
         fmt_done_ff <= 1'b0;
         data_ff     <= 1'b0;
         aux_ff      <= 1'b0;
      end else begin
         v_ff        <= v_in;
         phase_ff    <= phase_in;
         idx_ff      <= idx_in;
         pos_ff      <= pos_in;
         fmt_done_ff <= fmt_done_in;
         data_ff     <= data_in;
         aux_ff      <= aux_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
         last_ff <= in_last;
      end
      tag_ff  <= tag_in;
      size_ff <= size_in;
      skip_ff <= skip_in;
      ch_ff   <= ch_in;
      rate_ff <= rate_in;
      bits_ff <= bits_in;
      doff_ff <= doff_in;
      dlen_ff <= dlen_in;
   end

endmodule

[rtl/wavhp_rsp_buf.sv]
// Two-entry result buffer that decouples the parser from the result channel.
module wavhp_rsp_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wavhp_pkg::rsp_type push_data,
   output logic               room,
   output logic               out_valid,
   input  logic               out_ready,
   output wavhp_pkg::rsp_type out_data
);

   logic               v0_ff, v0_in, v1_ff, v1_in;
   wavhp_pkg::rsp_type d0_ff, d0_in, d1_ff, d1_in;
   logic               pop;

   assign pop       = v0_ff && out_ready;
   assign room      = !v1_ff;
   assign out_valid = v0_ff;
   assign out_data  = d0_ff;

   always_comb begin
      v0_in = v0_ff;
      v1_in = v1_ff;
      d0_in = d0_ff;
      d1_in = d1_ff;
      if (pop) begin
         // advance the second entry, or the new beat, to the head
         d0_in = v1_ff ? d1_ff : push_data;
         v0_in = v1_ff || push;
         d1_in = push_data;
         v1_in = v1_ff && push;
      end else if (push) begin
         if (!v0_ff) begin
            d0_in = push_data;
            v0_in = 1'b1;
         end else begin
            d1_in = push_data;
            v1_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      d0_ff <= d0_in;
      d1_ff <= d1_in;
   end

endmodule
